@@ rtl/core/lkvc_pkg.sv @@
// Shared constants, types and codes for the LRU key/value cache.
// No dependencies; compiled first.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    // Decided action for the item in flight
    typedef enum logic [2:0] {
        OP_NONE,
        OP_GET_HIT,
        OP_GET_MISS,
        OP_PUT_HIT,
        OP_PUT_REFUSE,
        OP_FILL,
        OP_EVICT
    } t_op;

    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_data;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } t_rsp_data;

endpackage

@@ rtl/core/lkvc_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on lkvc_pkg.
interface lkvc_req_if
    import lkvc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0] write_data;

    modport source (output valid, action, lookup_key, write_data, input ready);
    modport sink   (input valid, action, lookup_key, write_data, output ready);
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_data;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, read_data, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_data, evicted, evicted_key, output ready);
endinterface

@@ rtl/core/lkvc_ctrl.sv @@
// Sequencer for the cache: accept, lookup, update, response handshake.
// Depends on lkvc_pkg.
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                // wait for a free result slot
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_rsp_ready))
        else $error("result overwritten while waiting");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_LOOKUP))
        else $error("accepted item did not go to lookup");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_rsp_valid)
        else $error("committed result not presented");

endmodule

@@ rtl/core/lkvc_datapath.sv @@
// Entry store, key match, victim/free search, recency update, result register.
// Depends on lkvc_pkg.
module lkvc_datapath
    import lkvc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_cfg_wr_en,
    input  logic [CAP_W-1:0]         i_cfg_wr_data,
    input  logic                     i_action,
    input  logic signed [KEY_W-1:0]  i_lookup_key,
    input  logic signed [DATA_W-1:0] i_write_data,
    output t_rsp_data                o_rsp
);

    // entry store
    logic [KEY_W-1:0]  r_keys   [ENTRIES];
    logic [DATA_W-1:0] r_values [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [RANK_W-1:0] r_rank   [ENTRIES];
    logic [OCC_W-1:0]  r_occ;
    logic [CAP_W-1:0]  r_cap;

    // latched item
    logic              r_action;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_wdata;

    // lookup results
    t_op               r_op,       n_op;
    logic [IDX_W-1:0]  r_sel_idx,  n_sel_idx;
    logic [OCC_W-1:0]  r_sel_rank, n_sel_rank;
    logic [DATA_W-1:0] r_rd,       n_rd;
    logic [KEY_W-1:0]  r_evk,      n_evk;

    t_rsp_data         r_rsp;

    logic              any_hit, has_free, has_victim;
    logic [IDX_W-1:0]  hit_idx, free_idx, victim_idx;
    logic [OCC_W-1:0]  eff_cap, occ_m1;

    assign eff_cap = (32'(r_cap) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(r_cap);
    assign occ_m1  = r_occ - OCC_W'(1);

    // key match, lowest free entry, least recent entry
    always_comb begin
        any_hit    = 1'b0;
        has_free   = 1'b0;
        has_victim = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_keys[i] == r_key) begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (r_valid[i] && OCC_W'(r_rank[i]) == occ_m1) begin
                has_victim = 1'b1;
                victim_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_op       = OP_NONE;
        n_sel_idx  = hit_idx;
        n_sel_rank = OCC_W'(r_rank[hit_idx]);
        n_rd       = '0;
        n_evk      = '0;
        if (!r_action) begin
            if (any_hit) begin
                n_op = OP_GET_HIT;
                n_rd = r_values[hit_idx];
            end else begin
                n_op = OP_GET_MISS;
                n_rd = '1;
            end
        end else if (any_hit) begin
            n_op = OP_PUT_HIT;
        end else if (eff_cap == '0) begin
            // zero capacity: the key itself is turned away
            n_op  = OP_PUT_REFUSE;
            n_evk = r_key;
        end else if (r_occ < eff_cap) begin
            if (has_free) begin
                n_op       = OP_FILL;
                n_sel_idx  = free_idx;
                n_sel_rank = r_occ;
            end
        end else if (has_victim) begin
            n_op       = OP_EVICT;
            n_sel_idx  = victim_idx;
            n_sel_rank = OCC_W'(r_rank[victim_idx]);
            n_evk      = r_keys[victim_idx];
        end
    end

    logic do_touch, do_wr_value, do_wr_key, do_fill, rsp_hit, rsp_ev;

    always_comb begin
        do_touch    = 1'b0;
        do_wr_value = 1'b0;
        do_wr_key   = 1'b0;
        do_fill     = 1'b0;
        rsp_hit     = 1'b0;
        rsp_ev      = 1'b0;
        case (r_op) inside
            OP_GET_HIT: begin
                do_touch = 1'b1;
                rsp_hit  = 1'b1;
            end
            OP_PUT_HIT: begin
                do_touch    = 1'b1;
                do_wr_value = 1'b1;
                rsp_hit     = 1'b1;
            end
            OP_FILL: begin
                do_touch    = 1'b1;
                do_wr_value = 1'b1;
                do_wr_key   = 1'b1;
                do_fill     = 1'b1;
            end
            OP_EVICT: begin
                do_touch    = 1'b1;
                do_wr_value = 1'b1;
                do_wr_key   = 1'b1;
                rsp_ev      = 1'b1;
            end
            OP_PUT_REFUSE: rsp_ev = 1'b1;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_cap   <= i_cfg_wr_data;
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (do_touch) begin
                // entries younger than the touched one age by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && OCC_W'(r_rank[i]) < r_sel_rank) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
                r_rank[r_sel_idx] <= '0;
            end
            if (do_fill) begin
                r_valid[r_sel_idx] <= 1'b1;
                r_occ              <= r_occ + OCC_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_lookup_key;
            r_wdata  <= i_write_data;
        end
        if (i_cmd.lookup) begin
            r_op       <= n_op;
            r_sel_idx  <= n_sel_idx;
            r_sel_rank <= n_sel_rank;
            r_rd       <= n_rd;
            r_evk      <= n_evk;
        end
        if (i_cmd.commit) begin
            if (do_wr_value) begin
                r_values[r_sel_idx] <= r_wdata;
            end
            if (do_wr_key) begin
                r_keys[r_sel_idx] <= r_key;
            end
            r_rsp.hit         <= rsp_hit;
            r_rsp.read_data   <= r_rd;
            r_rsp.evicted     <= rsp_ev;
            r_rsp.evicted_key <= r_evk;
        end
    end

    assign o_rsp = r_rsp;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("occupancy out of step with valid bits");

    a_occ_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= eff_cap)
        else $error("occupancy above capacity");

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache.
// Depends on lkvc_pkg, lkvc_if, lkvc_ctrl, lkvc_datapath.
//
// Fully associative store of ENTRIES key/value pairs with least-recently-used
// replacement.
//   i_req  : request items {action, lookup_key, write_data}; action 0 = get,
//            1 = put.
//   o_rsp  : one result item per request {hit, read_data, evicted,
//            evicted_key}. A get miss returns read_data = -1; puts return 0.
//   i_cfg_wr_en / i_cfg_wr_data : capacity register write. A write empties
//            the store; issue it only while no item is in flight.
// Timing: a request is taken in the idle state, keys are compared in the
// next cycle, and the store update and result register load follow in the
// update state once the result register is free; result valid is loaded
// there. Items pass the accept/compare/update sequence on the shared store
// one at a time. A new request is taken while an earlier result still waits;
// the update stalls until the result register frees up, so a stalled
// receiver holds back at most one further item.
// Reset (synchronous, active low) empties the store and sets capacity to 16.
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    lkvc_req_if.sink         i_req,
    lkvc_rsp_if.source       o_rsp,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data
);

    t_cmd      cmd;
    t_rsp_data rsp_data;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_action      (i_req.action),
        .i_lookup_key  (i_req.lookup_key),
        .i_write_data  (i_req.write_data),
        .o_rsp         (rsp_data)
    );

    assign o_rsp.hit         = rsp_data.hit;
    assign o_rsp.read_data   = rsp_data.read_data;
    assign o_rsp.evicted     = rsp_data.evicted;
    assign o_rsp.evicted_key = rsp_data.evicted_key;

endmodule

@@ bench/lru_key_value_cache_test.sv @@
// Self-checking bench for lru_key_value_cache: directed and random get/put traffic.
// It predicts hit, read data and eviction with an LRU shadow store and checks each result.
// Depends on lkvc_pkg, lkvc_if and the cache RTL.
module lru_key_value_cache_test
    import lkvc_pkg::*;
;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_NEG = 32'hFFFF_FFFF;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int LONG_HOLD      = 300;   // receiver hold-off for the backpressure test
    localparam int PENDING_DEPTH  = 4;     // items queued ahead of the request driver
    localparam int DRAIN_CYCLES   = 8;     // quiet time at the end
    localparam int PHASE_ITEMS    = 61;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_request;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch.sink),
        .o_rsp         (rsp_ch.source),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the cache. Ranks: 0 = most recent among valid entries.
    logic [KEY_W-1:0]  shadow_key      [ENTRIES];
    logic [DATA_W-1:0] shadow_value    [ENTRIES];
    logic              shadow_valid    [ENTRIES];
    logic [RANK_W-1:0] shadow_rank     [ENTRIES];
    int                shadow_count;
    logic [CAP_W-1:0]  shadow_capacity;

    t_request  pending_q[$];       // items waiting for the request driver
    t_rsp_data expected_rsp_q[$];  // predicted results, oldest first

    bit gaps_on       = 1'b1;      // random idling on both channels
    int sink_hold_req = 0;         // long receiver hold-off, picked up by the sink process

    int mismatches    = 0;
    int rsp_seen      = 0;
    int req_accepted  = 0;
    int put_count     = 0;
    int hit_count     = 0;
    int evict_count   = 0;
    int cap_settings  = 1;         // reset value counts as the first setting

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // LRU shadow store
    // ------------------------------------------------------------------
    function automatic void clear_shadow();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_count = 0;
    endfunction

    // Promote one entry to most recent; only entries younger than it get older.
    function automatic void make_most_recent(input int slot);
        int                i;
        logic [RANK_W-1:0] old_rank;
        old_rank = shadow_rank[slot];
        for (i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] < old_rank)
                shadow_rank[i]++;
        shadow_rank[slot] = '0;
    endfunction

    // One access against the shadow store; returns the result the cache must give.
    function automatic t_rsp_data lru_access(input logic act,
                                             input logic [KEY_W-1:0] key,
                                             input logic [DATA_W-1:0] data);
        t_rsp_data rsp;
        int        i;
        int        slot;
        int        free_slot;
        int        victim;
        int        eff_cap;
        rsp       = '0;
        slot      = -1;
        free_slot = -1;
        victim    = -1;
        // capacity saturates at the array size
        eff_cap = (int'(shadow_capacity) > ENTRIES) ? ENTRIES : int'(shadow_capacity);
        for (i = 0; i < ENTRIES; i++)
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == key)
                slot = i;
        rsp.hit = (slot >= 0);

        if (act == ACT_GET) begin
            if (slot >= 0) begin
                rsp.read_data = shadow_value[slot];
                make_most_recent(slot);
            end else begin
                rsp.read_data = '1;  // miss reads as -1
            end
        end else if (slot >= 0) begin
            shadow_value[slot] = data;
            make_most_recent(slot);
        end else if (eff_cap == 0) begin
            // nothing can be held: the put bounces its own key
            rsp.evicted     = 1'b1;
            rsp.evicted_key = key;
        end else if (shadow_count < eff_cap) begin
            for (i = 0; i < ENTRIES; i++)
                if (free_slot < 0 && !shadow_valid[i])
                    free_slot = i;
            if (free_slot >= 0) begin
                for (i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i])
                        shadow_rank[i]++;
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot]   = key;
                shadow_value[free_slot] = data;
                shadow_rank[free_slot]  = '0;
                shadow_count++;
            end
        end else begin
            // full: replace the oldest entry in place
            for (i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                    victim = i;
            if (victim >= 0) begin
                rsp.evicted          = 1'b1;
                rsp.evicted_key      = shadow_key[victim];
                shadow_key[victim]   = key;
                shadow_value[victim] = data;
                make_most_recent(victim);
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. The head of pending_q stays on the bus until taken;
    // valid gets exactly one assignment per edge.
    // ------------------------------------------------------------------
    initial begin
        int req_gap;
        req_gap = 0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_GET;
        req_ch.lookup_key <= '0;
        req_ch.write_data <= '0;
        forever begin
            @(posedge clk);
            if (req_ch.valid && req_ch.ready) begin
                pending_q.delete(0);
                req_gap = gaps_on ? pick_gap() : 0;
            end
            if (req_gap > 0 || pending_q.size() == 0) begin
                req_ch.valid <= 1'b0;
                if (req_gap > 0)
                    req_gap--;
            end else begin
                req_ch.valid      <= 1'b1;
                req_ch.action     <= pending_q[0].action;
                req_ch.lookup_key <= pending_q[0].key;
                req_ch.write_data <= pending_q[0].data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int sink_stall;
        sink_stall = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold_req > 0) begin
                sink_stall    = sink_hold_req;
                sink_hold_req = 0;
            end
            if (sink_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                sink_stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    sink_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Mismatch report
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("MISMATCH result %0d %s: expected %h got %h", rsp_seen, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Prediction and checking. Requests are predicted before results are
    // compared, all in this one process, so same-edge ordering is fixed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_rsp_data want;
        t_rsp_data got;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                want = lru_access(req_ch.action, req_ch.lookup_key, req_ch.write_data);
                expected_rsp_q.push_back(want);
                req_accepted++;
                put_count   += int'(req_ch.action == ACT_PUT);
                hit_count   += int'(want.hit);
                evict_count += int'(want.evicted);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.hit         = rsp_ch.hit;
                got.read_data   = rsp_ch.read_data;
                got.evicted     = rsp_ch.evicted;
                got.evicted_key = rsp_ch.evicted_key;
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, got.read_data);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 32'(want.hit), 32'(got.hit));
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, got.read_data);
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
                    if (got.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", want.evicted_key, got.evicted_key);
                end
                rsp_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", quiet);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------
    task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] data);
        t_request item;
        while (pending_q.size() >= PENDING_DEPTH)
            @(posedge clk);
        item.action = act;
        item.key    = key;
        item.data   = data;
        pending_q.push_back(item);
    endtask

    // Returns at an edge once nothing is queued, offered or outstanding.
    // valid is read before this edge's update, so an item taken at this
    // very edge still counts as busy.
    task automatic drain_all();
        @(posedge clk);
        while (pending_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Capacity write, only with the cache idle; the write empties the store.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_capacity = value;
        clear_shadow();
        cap_settings++;
    endtask

    // Random gets and puts over a small key pool so hits and evictions are
    // common; one item in five uses a fresh random key.
    task automatic run_random_phase(input logic [CAP_W-1:0] cap_value, input bit write_it,
                                    input int count);
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        int               eff_cap;
        if (write_it)
            write_capacity(cap_value);
        eff_cap   = (int'(cap_value) > ENTRIES) ? ENTRIES : int'(cap_value);
        pool_size = eff_cap + 3;
        repeat (pool_size)
            key_pool.push_back($urandom);
        repeat (count) begin
            if ($urandom_range(0, 4) != 0)
                key = key_pool[$urandom_range(0, pool_size - 1)];
            else
                key = $urandom;
            send_request(logic'($urandom_range(0, 1)), key, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty store after reset, extreme keys and values, update of a present key.
    task automatic test_basic_access();
        send_request(ACT_GET, '0, '0);              // miss on empty store
        send_request(ACT_PUT, KEY_MAX, KEY_MIN);
        send_request(ACT_PUT, KEY_MIN, KEY_MAX);
        send_request(ACT_GET, KEY_MAX, '0);
        send_request(ACT_GET, KEY_NEG, '0);         // miss: -1 as read data
        send_request(ACT_PUT, KEY_NEG, 32'hFFFF_FFFF);
        send_request(ACT_GET, KEY_NEG, '0);         // hit whose value is also -1
        send_request(ACT_PUT, KEY_MAX, '0);         // update in place
        send_request(ACT_GET, KEY_MAX, 32'hFFFF_FFFF);
    endtask

    // Reset capacity of 16 with more live keys than entries.
    task automatic test_default_capacity();
        run_random_phase(CAP_RESET, 1'b0, PHASE_ITEMS);
    endtask

    // Recency order decides the victim; a capacity write empties the store.
    task automatic test_lru_eviction();
        write_capacity(5'd2);
        send_request(ACT_PUT, 32'd1, 32'hA);
        send_request(ACT_PUT, 32'd2, 32'hB);
        send_request(ACT_GET, 32'd1, '0);           // key 1 now most recent
        send_request(ACT_PUT, 32'd3, 32'hC);        // evicts key 2
        send_request(ACT_GET, 32'd2, '0);           // miss
        send_request(ACT_PUT, 32'd4, 32'hD);        // evicts key 1
        send_request(ACT_GET, 32'd3, '0);
        write_capacity(5'd2);
        send_request(ACT_GET, 32'd3, '0);           // gone after the write
    endtask

    // Single entry: every new key replaces the previous one.
    task automatic test_capacity_one();
        write_capacity(5'd1);
        send_request(ACT_PUT, 32'd5, 32'h55);
        send_request(ACT_PUT, 32'd6, 32'h66);
    endtask

    // No entries: a put bounces its own key, a get always misses.
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_request(ACT_PUT, KEY_MIN, 32'h1234_5678);
        send_request(ACT_GET, KEY_MIN, '0);
    endtask

    // Receiver holds off while items keep coming, so the cache stalls its
    // input; then the sender waits for every result before the next burst.
    task automatic test_backpressure();
        int n;
        write_capacity(5'd4);
        gaps_on       = 1'b0;
        sink_hold_req = LONG_HOLD;
        for (n = 0; n < 12; n++)
            send_request(logic'($urandom_range(0, 1)), $urandom_range(0, 6), $urandom);
        drain_all();
        for (n = 0; n < 12; n++)
            send_request(logic'($urandom_range(0, 1)), $urandom_range(0, 6), $urandom);
        drain_all();
        gaps_on = 1'b1;
    endtask

    // Random traffic across small, full, saturated and zero capacities;
    // one phase runs with no idling at all.
    task automatic test_random_mix();
        run_random_phase(5'd1, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd2, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd3, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd5, 1'b1, PHASE_ITEMS);
        gaps_on = 1'b0;
        run_random_phase(5'd8, 1'b1, PHASE_ITEMS);
        drain_all();
        gaps_on = 1'b1;
        run_random_phase(5'd15, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd16, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd17, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd31, 1'b1, PHASE_ITEMS);
        run_random_phase(5'd0, 1'b1, PHASE_ITEMS / 2);
        run_random_phase(CAP_W'($urandom_range(0, 31)), 1'b1, PHASE_ITEMS);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        shadow_capacity = CAP_RESET;
        clear_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_access();
        test_default_capacity();
        test_lru_eviction();
        test_capacity_one();
        test_capacity_zero();
        test_backpressure();
        test_random_mix();

        drain_all();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d puts, %0d hits, %0d evictions), %0d results checked,",
                 req_accepted, put_count, hit_count, evict_count, rsp_seen);
        $display("over %0d capacity settings incl. 0, 1, 16 and 31, with stalls on both sides.",
                 cap_settings);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_if.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lkvc_datapath.sv
rtl/core/lru_key_value_cache.sv
bench/lru_key_value_cache_test.sv
